>>> src/uvs_pkg.sv
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared widths, fixed-point constants, codes and bundle types of the UV
// sphere mesh generator.
// ----------------------------------------------------------------------------
package uvs_pkg;

	localparam int MAX_SEGMENTS    = 255;
	localparam int TRIG_ITERATIONS = 16;

	localparam int SEG_W  = 8;
	localparam int RAD_W  = 24;
	localparam int POS_W  = 25;
	localparam int NRM_W  = 16;
	localparam int TEX_W  = 17;
	localparam int IDX_W  = 16;
	localparam int QUO_W  = 31;
	localparam int ANG_W  = 33;
	localparam int TRIG_W = 32;
	localparam int CRD_W  = 34;

	localparam logic signed [ANG_W-1:0] Q28_PI      = 33'sd843314857;
	localparam logic signed [ANG_W-1:0] Q28_HALF_PI = 33'sd421657428;
	localparam logic signed [ANG_W-1:0] Q28_TWO_PI  = 33'sd1686629713;
	localparam logic signed [CRD_W-1:0] Q30_ONE     = 34'sd1073741824;
	localparam logic signed [CRD_W-1:0] CORDIC_GAIN = 34'sd652032874;

	localparam logic signed [ANG_W-1:0] ATAN_SMALL [10] = '{
		33'sd210828714, 33'sd124459457, 33'sd65760959, 33'sd33381290,
		33'sd16755422, 33'sd8385879, 33'sd4193963, 33'sd2097109,
		33'sd1048571, 33'sd524287
	};

	typedef enum logic {
		REQ_VERTEX = 1'b0,
		REQ_QUAD   = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		REG_SEGMENTS = 2'd0,
		REG_RADIUS_X = 2'd1,
		REG_RADIUS_Y = 2'd2,
		REG_RADIUS_Z = 2'd3
	} reg_idx_t;

	typedef struct packed {
		req_t             req_type;
		logic [TEX_W-1:0] tex_u;
		logic [TEX_W-1:0] tex_v;
		logic [IDX_W-1:0] idx_up;
		logic [IDX_W-1:0] idx_lo;
	} side_t;

	typedef struct packed {
		logic signed [TRIG_W-1:0] sin_t;
		logic signed [TRIG_W-1:0] cos_t;
		logic signed [TRIG_W-1:0] sin_p;
		logic signed [TRIG_W-1:0] cos_p;
	} trig_t;

	typedef struct packed {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic signed [POS_W-1:0] z;
	} pos_t;

	typedef struct packed {
		logic signed [NRM_W-1:0] x;
		logic signed [NRM_W-1:0] y;
		logic signed [NRM_W-1:0] z;
	} nrm_t;

	function automatic logic signed [ANG_W-1:0] atan_entry(input int k);
		logic signed [ANG_W-1:0] v;
		v = '0;
		if (k < 10)
			v = ATAN_SMALL[k[3:0]];
		else if (k < 28)
			v = ANG_W'(1) <<< (28 - k);
		return v;
	endfunction

endpackage

>>> src/uvs_front.sv
// ----------------------------------------------------------------------------
// uvs_front
// Index clamping, quad index arithmetic, and a bit-per-stage divider that
// yields both angles and both texture coordinates.
// ----------------------------------------------------------------------------
module uvs_front
	import uvs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [SEG_W-1:0] segments,
	input  logic             in_vld,
	input  req_t             req_type,
	input  logic [SEG_W-1:0] ring,
	input  logic [SEG_W-1:0] column,
	output logic             out_vld,
	output logic [QUO_W-1:0] theta_q,
	output logic [QUO_W-1:0] phi_q,
	output side_t            side
);

	localparam int DIV_W = 40;
	localparam int LANES = 4;
	localparam int L_THETA = 0;
	localparam int L_PHI   = 1;
	localparam int L_TU    = 2;
	localparam int L_TV    = 3;

	logic [SEG_W-1:0] n_eff, i_v, j_v, i_q, j_q;

	logic             vld_s1;
	req_t             type_s1;
	logic [SEG_W-1:0] n_s1, iv_s1, jv_s1, iq_s1, jq_s1;

	logic [SEG_W:0]   span;
	logic [16:0]      up_full, lo_full;

	logic             vld_s [QUO_W+1];
	req_t             type_s [QUO_W+1];
	logic [SEG_W-1:0] n_s [QUO_W+1];
	logic [IDX_W-1:0] up_s [QUO_W+1];
	logic [IDX_W-1:0] lo_s [QUO_W+1];
	logic [DIV_W-1:0] rem_s [QUO_W+1][LANES];
	logic [QUO_W-1:0] quo_s [QUO_W+1][LANES];

	always_comb begin
		n_eff = segments;
		if (segments == '0)
			n_eff = SEG_W'(1);
		else if (segments > SEG_W'(MAX_SEGMENTS))
			n_eff = SEG_W'(MAX_SEGMENTS);
		i_v = (ring > n_eff) ? n_eff : ring;
		j_v = (column > n_eff) ? n_eff : column;
		i_q = ring;
		if (ring == '0)
			i_q = SEG_W'(1);
		else if (ring > n_eff)
			i_q = n_eff;
		j_q = (column > n_eff - SEG_W'(1)) ? n_eff - SEG_W'(1) : column;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (en)
			vld_s1 <= in_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			type_s1 <= req_type;
			n_s1    <= n_eff;
			iv_s1   <= i_v;
			jv_s1   <= j_v;
			iq_s1   <= i_q;
			jq_s1   <= j_q;
		end
	end

	always_comb begin
		span    = {1'b0, n_s1} + (SEG_W+1)'(1);
		up_full = 17'(span) * 17'(iq_s1 - SEG_W'(1)) + 17'(jq_s1);
		lo_full = up_full + 17'(span);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s[0] <= 1'b0;
		else if (en)
			vld_s[0] <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			type_s[0] <= type_s1;
			n_s[0]    <= n_s1;
			up_s[0]   <= up_full[IDX_W-1:0];
			lo_s[0]   <= lo_full[IDX_W-1:0];
			rem_s[0][L_THETA] <= DIV_W'(iv_s1) * DIV_W'(Q28_TWO_PI) + DIV_W'(n_s1);
			rem_s[0][L_PHI]   <= DIV_W'(jv_s1) * DIV_W'(Q28_TWO_PI) + DIV_W'(n_s1 >> 1);
			rem_s[0][L_TU]    <= (DIV_W'(jv_s1) << 16) + DIV_W'(n_s1 >> 1);
			rem_s[0][L_TV]    <= (DIV_W'(iv_s1) << 16) + DIV_W'(n_s1 >> 1);
			for (int l = 0; l < LANES; l++)
				quo_s[0][l] <= '0;
		end
	end

	for (genvar k = 0; k < QUO_W; k++) begin : g_div
		logic [DIV_W-1:0] trial [LANES];
		logic             take  [LANES];

		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				if (l == L_THETA)
					trial[l] = DIV_W'({n_s[k], 1'b0}) << (QUO_W - 1 - k);
				else
					trial[l] = DIV_W'(n_s[k]) << (QUO_W - 1 - k);
				take[l] = (rem_s[k][l] >= trial[l]);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k+1] <= 1'b0;
			else if (en)
				vld_s[k+1] <= vld_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				type_s[k+1] <= type_s[k];
				n_s[k+1]    <= n_s[k];
				up_s[k+1]   <= up_s[k];
				lo_s[k+1]   <= lo_s[k];
				for (int l = 0; l < LANES; l++) begin
					rem_s[k+1][l] <= take[l] ? rem_s[k][l] - trial[l] : rem_s[k][l];
					quo_s[k+1][l] <= {quo_s[k][l][QUO_W-2:0], take[l]};
				end
			end
		end
	end

	assign out_vld       = vld_s[QUO_W];
	assign theta_q       = quo_s[QUO_W][L_THETA];
	assign phi_q         = quo_s[QUO_W][L_PHI];
	assign side.req_type = type_s[QUO_W];
	assign side.tex_u    = TEX_W'(quo_s[QUO_W][L_TU]);
	assign side.tex_v    = TEX_W'(65536) - TEX_W'(quo_s[QUO_W][L_TV]);
	assign side.idx_up   = up_s[QUO_W];
	assign side.idx_lo   = lo_s[QUO_W];

endmodule

>>> src/uvs_cordic.sv
// ----------------------------------------------------------------------------
// uvs_cordic
// Two-lane rotation CORDIC, one micro-rotation per stage, with quadrant fold
// in front and sign restore and clamp behind.
// ----------------------------------------------------------------------------
module uvs_cordic
	import uvs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  logic [QUO_W-1:0] theta_q,
	input  logic [QUO_W-1:0] phi_q,
	input  side_t            side_in,
	output logic             out_vld,
	output trig_t            trig,
	output side_t            side_out
);

	localparam int LANES = 2;
	localparam int NI    = TRIG_ITERATIONS;

	logic signed [ANG_W-1:0] a_in [LANES];
	logic signed [ANG_W-1:0] a_wrap [LANES];

	logic                    vld_f1;
	side_t                   side_f1;
	logic signed [ANG_W-1:0] a_f1 [LANES];

	logic signed [ANG_W-1:0] a_fold [LANES];
	logic                    flip_fold [LANES];

	logic                    vld_s  [NI+1];
	side_t                   side_s [NI+1];
	logic signed [CRD_W-1:0] x_s    [NI+1][LANES];
	logic signed [CRD_W-1:0] y_s    [NI+1][LANES];
	logic signed [ANG_W-1:0] a_s    [NI+1][LANES];
	logic                    flip_s [NI+1][LANES];

	logic signed [CRD_W-1:0] xo [LANES];
	logic signed [CRD_W-1:0] yo [LANES];

	always_comb begin
		a_in[0] = $signed({2'b00, theta_q});
		a_in[1] = $signed({2'b00, phi_q});
		for (int l = 0; l < LANES; l++)
			a_wrap[l] = (a_in[l] > Q28_PI) ? a_in[l] - Q28_TWO_PI : a_in[l];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_f1 <= 1'b0;
		else if (en)
			vld_f1 <= in_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_f1 <= side_in;
			for (int l = 0; l < LANES; l++)
				a_f1[l] <= a_wrap[l];
		end
	end

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			a_fold[l]    = a_f1[l];
			flip_fold[l] = 1'b0;
			if (a_f1[l] > Q28_HALF_PI) begin
				a_fold[l]    = a_f1[l] - Q28_PI;
				flip_fold[l] = 1'b1;
			end else if (a_f1[l] < -Q28_HALF_PI) begin
				a_fold[l]    = a_f1[l] + Q28_PI;
				flip_fold[l] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s[0] <= 1'b0;
		else if (en)
			vld_s[0] <= vld_f1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_f1;
			for (int l = 0; l < LANES; l++) begin
				x_s[0][l]    <= CORDIC_GAIN;
				y_s[0][l]    <= '0;
				a_s[0][l]    <= a_fold[l];
				flip_s[0][l] <= flip_fold[l];
			end
		end
	end

	for (genvar k = 0; k < NI; k++) begin : g_rot
		localparam logic signed [ANG_W-1:0] ATAN_K = atan_entry(k);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k+1] <= 1'b0;
			else if (en)
				vld_s[k+1] <= vld_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k+1] <= side_s[k];
				for (int l = 0; l < LANES; l++) begin
					flip_s[k+1][l] <= flip_s[k][l];
					if (!a_s[k][l][ANG_W-1]) begin
						x_s[k+1][l] <= x_s[k][l] - (y_s[k][l] >>> k);
						y_s[k+1][l] <= y_s[k][l] + (x_s[k][l] >>> k);
						a_s[k+1][l] <= a_s[k][l] - ATAN_K;
					end else begin
						x_s[k+1][l] <= x_s[k][l] + (y_s[k][l] >>> k);
						y_s[k+1][l] <= y_s[k][l] - (x_s[k][l] >>> k);
						a_s[k+1][l] <= a_s[k][l] + ATAN_K;
					end
				end
			end
		end
	end

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			xo[l] = flip_s[NI][l] ? -x_s[NI][l] : x_s[NI][l];
			yo[l] = flip_s[NI][l] ? -y_s[NI][l] : y_s[NI][l];
			if (xo[l] > Q30_ONE)
				xo[l] = Q30_ONE;
			else if (xo[l] < -Q30_ONE)
				xo[l] = -Q30_ONE;
			if (yo[l] > Q30_ONE)
				yo[l] = Q30_ONE;
			else if (yo[l] < -Q30_ONE)
				yo[l] = -Q30_ONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld <= 1'b0;
		else if (en)
			out_vld <= vld_s[NI];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_out   <= side_s[NI];
			trig.sin_t <= TRIG_W'(yo[0]);
			trig.cos_t <= TRIG_W'(xo[0]);
			trig.sin_p <= TRIG_W'(yo[1]);
			trig.cos_p <= TRIG_W'(xo[1]);
		end
	end

endmodule

>>> src/uvs_pos.sv
// ----------------------------------------------------------------------------
// uvs_pos
// Scales the trig terms by the semi-axes: multiply, round, multiply, round.
// ----------------------------------------------------------------------------
module uvs_pos
	import uvs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  trig_t            trig,
	input  side_t            side_in,
	input  logic [RAD_W-1:0] radius_x,
	input  logic [RAD_W-1:0] radius_y,
	input  logic [RAD_W-1:0] radius_z,
	output logic             out_vld,
	output pos_t             pos,
	output side_t            side_out
);

	localparam int P1_W = RAD_W + 1 + TRIG_W;
	localparam int R1_W = RAD_W + 3;
	localparam int P2_W = R1_W + TRIG_W;
	localparam logic signed [P1_W-1:0] RND1 = P1_W'(64'sd536870912);
	localparam logic signed [P2_W-1:0] RND2 = P2_W'(64'sd536870912);

	logic                     vld_s1, vld_s2, vld_s3;
	side_t                    side_s1, side_s2, side_s3;
	logic signed [P1_W-1:0]   mx_s1, my_s1, mz_s1;
	logic signed [TRIG_W-1:0] st_s1, st_s2;
	logic signed [R1_W-1:0]   rx_s2, rz_s2;
	logic signed [POS_W-1:0]  py_s2, py_s3;
	logic signed [P2_W-1:0]   mx_s3, mz_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			out_vld <= 1'b0;
		end else if (en) begin
			vld_s1  <= in_vld;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			out_vld <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1  <= side_in;
			mx_s1    <= $signed({1'b0, radius_x}) * trig.sin_p;
			my_s1    <= $signed({1'b0, radius_y}) * trig.cos_t;
			mz_s1    <= $signed({1'b0, radius_z}) * trig.cos_p;
			st_s1    <= trig.sin_t;

			side_s2  <= side_s1;
			rx_s2    <= R1_W'((mx_s1 + RND1) >>> 30);
			py_s2    <= POS_W'((my_s1 + RND1) >>> 30);
			rz_s2    <= R1_W'((mz_s1 + RND1) >>> 30);
			st_s2    <= st_s1;

			side_s3  <= side_s2;
			mx_s3    <= rx_s2 * st_s2;
			mz_s3    <= rz_s2 * st_s2;
			py_s3    <= py_s2;

			side_out <= side_s3;
			pos.x    <= POS_W'((mx_s3 + RND2) >>> 30);
			pos.y    <= py_s3;
			pos.z    <= POS_W'((mz_s3 + RND2) >>> 30);
		end
	end

endmodule

>>> src/uvs_norm.sv
// ----------------------------------------------------------------------------
// uvs_norm
// Unit normal: sum of squares, digit-by-digit square root, then a three-lane
// bit-per-stage divider with rounding and saturation.
// ----------------------------------------------------------------------------
module uvs_norm
	import uvs_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_vld,
	input  pos_t  pos_in,
	input  side_t side_in,
	output logic  out_vld,
	output pos_t  pos_out,
	output nrm_t  nrm,
	output side_t side_out
);

	localparam int LANES = 3;
	localparam int SQ_W  = 2 * POS_W;
	localparam int V_W   = 64;
	localparam int NSQ   = 32;
	localparam int LEN_W = 32;
	localparam int ND_W  = 48;
	localparam int NQ    = 17;
	localparam int MAG_W = POS_W;

	typedef struct packed {
		side_t side;
		pos_t  pos;
		logic  nz;
	} carry_t;

	logic signed [POS_W-1:0] p_in [LANES];
	logic signed [POS_W-1:0] p_d0 [LANES];
	logic [MAG_W-1:0]        mag  [LANES];

	logic             vld_n1;
	carry_t           c_n1;
	logic [SQ_W-1:0]  sq_n1 [LANES];

	logic             vld_q [NSQ+1];
	carry_t           c_q   [NSQ+1];
	logic [V_W-1:0]   v_q   [NSQ+1];
	logic [V_W-1:0]   r_q   [NSQ+1];

	logic             vld_d [NQ+1];
	carry_t           c_d   [NQ+1];
	logic [LEN_W-1:0] len_d [NQ+1];
	logic [ND_W-1:0]  rem_d [NQ+1][LANES];
	logic [NQ-1:0]    quo_d [NQ+1][LANES];

	logic signed [NRM_W-1:0] nv [LANES];

	always_comb begin
		p_in[0] = pos_in.x;
		p_in[1] = pos_in.y;
		p_in[2] = pos_in.z;
		p_d0[0] = c_q[NSQ].pos.x;
		p_d0[1] = c_q[NSQ].pos.y;
		p_d0[2] = c_q[NSQ].pos.z;
		for (int l = 0; l < LANES; l++)
			mag[l] = p_d0[l][POS_W-1] ? MAG_W'(-p_d0[l]) : MAG_W'(p_d0[l]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_n1   <= 1'b0;
			vld_q[0] <= 1'b0;
			vld_d[0] <= 1'b0;
		end else if (en) begin
			vld_n1   <= in_vld;
			vld_q[0] <= vld_n1;
			vld_d[0] <= vld_q[NSQ];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_n1.side <= side_in;
			c_n1.pos  <= pos_in;
			c_n1.nz   <= (pos_in.x != '0) || (pos_in.y != '0) || (pos_in.z != '0);
			for (int l = 0; l < LANES; l++)
				sq_n1[l] <= SQ_W'(p_in[l] * p_in[l]);

			c_q[0] <= c_n1;
			v_q[0] <= (V_W'(sq_n1[0]) + V_W'(sq_n1[1]) + V_W'(sq_n1[2])) << 12;
			r_q[0] <= '0;

			c_d[0]   <= c_q[NSQ];
			len_d[0] <= LEN_W'(r_q[NSQ]);
			for (int l = 0; l < LANES; l++) begin
				rem_d[0][l] <= (ND_W'(mag[l]) << 21) + ND_W'(r_q[NSQ][LEN_W-1:1]);
				quo_d[0][l] <= '0;
			end
		end
	end

	for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
		localparam logic [V_W-1:0] BIT_K = V_W'(1) << (62 - 2 * k);
		logic [V_W-1:0] trial;

		assign trial = r_q[k] + BIT_K;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_q[k+1] <= 1'b0;
			else if (en)
				vld_q[k+1] <= vld_q[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				c_q[k+1] <= c_q[k];
				if (v_q[k] >= trial) begin
					v_q[k+1] <= v_q[k] - trial;
					r_q[k+1] <= (r_q[k] >> 1) + BIT_K;
				end else begin
					v_q[k+1] <= v_q[k];
					r_q[k+1] <= r_q[k] >> 1;
				end
			end
		end
	end

	for (genvar k = 0; k < NQ; k++) begin : g_div
		logic [ND_W-1:0] trial;
		logic            take [LANES];

		assign trial = ND_W'(len_d[k]) << (NQ - 1 - k);

		always_comb begin
			for (int l = 0; l < LANES; l++)
				take[l] = (rem_d[k][l] >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_d[k+1] <= 1'b0;
			else if (en)
				vld_d[k+1] <= vld_d[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				c_d[k+1]   <= c_d[k];
				len_d[k+1] <= len_d[k];
				for (int l = 0; l < LANES; l++) begin
					rem_d[k+1][l] <= take[l] ? rem_d[k][l] - trial : rem_d[k][l];
					quo_d[k+1][l] <= {quo_d[k][l][NQ-2:0], take[l]};
				end
			end
		end
	end

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			nv[l] = '0;
			if (c_d[NQ].nz) begin
				if (l == 0 ? c_d[NQ].pos.x[POS_W-1] :
				    l == 1 ? c_d[NQ].pos.y[POS_W-1] : c_d[NQ].pos.z[POS_W-1]) begin
					if (quo_d[NQ][l] > NQ'(32768))
						nv[l] = NRM_W'(-32768);
					else
						nv[l] = NRM_W'(NQ'(0) - quo_d[NQ][l]);
				end else begin
					if (quo_d[NQ][l] > NQ'(32767))
						nv[l] = NRM_W'(32767);
					else
						nv[l] = NRM_W'(quo_d[NQ][l]);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld <= 1'b0;
		else if (en)
			out_vld <= vld_d[NQ];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_out <= c_d[NQ].side;
			pos_out  <= c_d[NQ].pos;
			nrm.x    <= nv[0];
			nrm.y    <= nv[1];
			nrm.z    <= nv[2];
		end
	end

endmodule

>>> src/uv_sphere_mesh_generator.sv
// ----------------------------------------------------------------------------
// uv_sphere_mesh_generator
// Throughput: one vertex request per cycle while m_axis_tready is high; a quad
// request holds the output register for two words, and the input stalls meanwhile.
// Reset clears the valid chain and the output valid and phase, and loads the configuration defaults.
// ----------------------------------------------------------------------------
module uv_sphere_mesh_generator
	import uvs_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [23:0]  cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [15:0]  s_axis_tdata,   // ring, column
	input  logic         s_axis_tuser,   // req_type
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [207:0] m_axis_tdata,   // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
	                                     // tex_u, tex_v, idx_a, idx_b, idx_c, zero pad
	output logic         m_axis_tlast
);

	logic [SEG_W-1:0] segments_q;
	logic [RAD_W-1:0] radius_x_q, radius_y_q, radius_z_q;

	logic             en;
	logic             fr_vld, cd_vld, ps_vld, nm_vld;
	logic [QUO_W-1:0] theta_q, phi_q;
	side_t            fr_side, cd_side, ps_side, nm_side;
	trig_t            trig;
	pos_t             ps_pos, nm_pos;
	nrm_t             nm_nrm;

	logic             out_vld_q, phase_q;
	side_t            out_side_q;
	pos_t             out_pos_q;
	nrm_t             out_nrm_q;

	logic [IDX_W-1:0] idx_a, idx_b, idx_c;
	pos_t             o_pos;
	nrm_t             o_nrm;
	logic [TEX_W-1:0] o_tu, o_tv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			segments_q <= SEG_W'(32);
			radius_x_q <= RAD_W'(256);
			radius_y_q <= RAD_W'(256);
			radius_z_q <= RAD_W'(256);
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SEGMENTS: segments_q <= cfg_data[SEG_W-1:0];
				REG_RADIUS_X: radius_x_q <= cfg_data;
				REG_RADIUS_Y: radius_y_q <= cfg_data;
				REG_RADIUS_Z: radius_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// advance the whole pipe unless the output word is held
	assign en = !out_vld_q ||
	            (m_axis_tready && (out_side_q.req_type == REQ_VERTEX || phase_q));
	assign s_axis_tready = en;

	uvs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.segments (segments_q),
		.in_vld   (s_axis_tvalid),
		.req_type (req_t'(s_axis_tuser)),
		.ring     (s_axis_tdata[7:0]),
		.column   (s_axis_tdata[15:8]),
		.out_vld  (fr_vld),
		.theta_q  (theta_q),
		.phi_q    (phi_q),
		.side     (fr_side)
	);

	uvs_cordic u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (fr_vld),
		.theta_q  (theta_q),
		.phi_q    (phi_q),
		.side_in  (fr_side),
		.out_vld  (cd_vld),
		.trig     (trig),
		.side_out (cd_side)
	);

	uvs_pos u_pos (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (cd_vld),
		.trig     (trig),
		.side_in  (cd_side),
		.radius_x (radius_x_q),
		.radius_y (radius_y_q),
		.radius_z (radius_z_q),
		.out_vld  (ps_vld),
		.pos      (ps_pos),
		.side_out (ps_side)
	);

	uvs_norm u_norm (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (ps_vld),
		.pos_in   (ps_pos),
		.side_in  (ps_side),
		.out_vld  (nm_vld),
		.pos_out  (nm_pos),
		.nrm      (nm_nrm),
		.side_out (nm_side)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			phase_q   <= 1'b0;
		end else if (en) begin
			out_vld_q <= nm_vld;
			phase_q   <= 1'b0;
		end else if (m_axis_tready) begin
			phase_q   <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_side_q <= nm_side;
			out_pos_q  <= nm_pos;
			out_nrm_q  <= nm_nrm;
		end
	end

	always_comb begin
		o_pos = '0;
		o_nrm = '0;
		o_tu  = '0;
		o_tv  = '0;
		idx_a = '0;
		idx_b = '0;
		idx_c = '0;
		m_axis_tlast = 1'b1;
		unique case (out_side_q.req_type)
			REQ_VERTEX: begin
				o_pos = out_pos_q;
				o_nrm = out_nrm_q;
				o_tu  = out_side_q.tex_u;
				o_tv  = out_side_q.tex_v;
			end
			REQ_QUAD: begin
				idx_a = out_side_q.idx_up;
				m_axis_tlast = phase_q;
				if (phase_q) begin
					idx_b = out_side_q.idx_lo + IDX_W'(1);
					idx_c = out_side_q.idx_up + IDX_W'(1);
				end else begin
					idx_b = out_side_q.idx_lo;
					idx_c = out_side_q.idx_lo + IDX_W'(1);
				end
			end
			default: ;
		endcase
		m_axis_tdata = {3'b000, idx_c, idx_b, idx_a, o_tv, o_tu,
		                o_nrm.z, o_nrm.y, o_nrm.x, o_pos.z, o_pos.y, o_pos.x};
	end

	assign m_axis_tvalid = out_vld_q;

endmodule

>>> src/uvs_checker.sv
// ----------------------------------------------------------------------------
// uvs_checker
// Port-level checks of the mesh generator stream, bound to the top level.
// ----------------------------------------------------------------------------
module uvs_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [207:0] m_axis_tdata,
	input logic         m_axis_tlast
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output word dropped or changed while stalled");

	a_quad_pair: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid && m_axis_tlast)
		else $error("second triangle does not follow the first");

	a_ready_only_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !(m_axis_tready && m_axis_tlast))
		else $error("input stalled without a held output word");

	a_quad_no_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[156:0] == '0)
		else $error("triangle word carries vertex fields");

endmodule

bind uv_sphere_mesh_generator uvs_checker u_uvs_checker (.*);
